@@ src/ppe_pkg.sv @@
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants of the partial permutation engine
// Command codes, controller-to-datapath command struct and status struct.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam logic [2:0] CmdSet     = 3'd0;
  localparam logic [2:0] CmdPush    = 3'd1;
  localparam logic [2:0] CmdPop     = 3'd2;
  localparam logic [2:0] CmdSwap    = 3'd3;
  localparam logic [2:0] CmdReverse = 3'd4;
  localparam logic [2:0] CmdNext    = 3'd5;

  localparam logic [15:0] MaskAllOnes = '1;

  // Datapath operations issued by the controller.
  localparam logic [2:0] OpNone    = 3'd0;
  localparam logic [2:0] OpLoad    = 3'd1; // latch the input word
  localparam logic [2:0] OpSimple  = 3'd2; // set, push, pop
  localparam logic [2:0] OpSwapIJ  = 3'd3; // swap the entries at the two cursors, step them
  localparam logic [2:0] OpScanDn  = 3'd4; // step cursor i down
  localparam logic [2:0] OpPivot   = 3'd5; // prepare the successor search
  localparam logic [2:0] OpScanJ   = 3'd6; // step cursor j down
  localparam logic [2:0] OpSwapPiv = 3'd7; // swap pivot, start reversal

  typedef struct packed {
    logic [2:0] op;
  } ctrl_t;

  typedef struct packed {
    logic rev_more;   // cursors of the reversal have not met
    logic scan_more;  // descending run continues below cursor i
    logic j_more;     // entry at j is not above the pivot
    logic at_lo;      // cursor i reached the range begin
    logic is_next;    // latched command is next permutation
    logic is_rev;     // latched command is reverse or swap
    logic ok;         // preconditions hold
  } stat_t;

endpackage

@@ src/ppe_datapath.sv @@
// ----------------------------------------------------------------------------
// ppe_datapath: entry store, counters and cursors of the permutation engine
// Executes one operation per cycle as the controller commands.
// ----------------------------------------------------------------------------
module ppe_datapath #(
  parameter int unsigned MaxLength = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [4:0]      perm_length_i,
  input  logic [2:0]      command_i,
  input  logic [4:0]      index_a_i,
  input  logic [4:0]      index_b_i,
  input  logic [3:0]      value_i,
  input  ppe_pkg::ctrl_t  ctrl_i,
  output ppe_pkg::stat_t  stat_o,
  output logic            status_o,
  output logic            advanced_o,
  output logic [4:0]      filled_count_o,
  output logic [15:0]     unused_mask_o,
  output logic [3:0]      entry_at_a_o
);
  import ppe_pkg::*;

  localparam int unsigned IW = $clog2(MaxLength + 1) > 5 ? $clog2(MaxLength + 1) : 5;
  localparam int unsigned AW = $clog2(MaxLength);

  logic [3:0]    mem_q [MaxLength];
  logic [IW-1:0] fill_q, fill_d;
  logic [15:0]   mask_q, mask_d;
  logic [2:0]    cmd_q;
  logic [IW-1:0] a_q, b_q, i_q, j_q, piv_q;
  logic [3:0]    v_q;
  logic          adv_q;
  logic          pend_q;
  logic          rej_q;
  logic [IW-1:0] len;
  logic [IW-1:0] a_w, b_w, plen_w, bm1_w;
  logic          ok;

  assign plen_w = IW'(perm_length_i);
  assign len    = (plen_w > IW'(MaxLength)) ? IW'(MaxLength) : plen_w;
  assign a_w    = IW'(index_a_i);
  assign b_w    = IW'(index_b_i);
  assign bm1_w  = (b_w == '0) ? '0 : b_w - 1'b1;

  always_comb begin
    ok = 1'b0;
    case (cmd_q)
      CmdSet:     ok = (a_q == fill_q && fill_q < len) || (a_q < fill_q && fill_q <= len);
      CmdPush:    ok = fill_q < len;
      CmdPop:     ok = 1'b1;
      CmdSwap:    ok = a_q < fill_q && b_q < fill_q;
      CmdReverse: ok = a_q < fill_q && b_q <= fill_q && a_q <= b_q;
      CmdNext:    ok = fill_q == len && b_q <= len && a_q <= b_q;
      default:    ok = 1'b0;
    endcase
  end

  logic [3:0] ei, ej, eim1, epiv;
  assign ei   = mem_q[i_q[AW-1:0]];
  assign ej   = mem_q[j_q[AW-1:0]];
  assign eim1 = mem_q[AW'(i_q - 1'b1)];
  assign epiv = mem_q[piv_q[AW-1:0]];

  assign stat_o.ok        = ok;
  assign stat_o.is_next   = cmd_q == CmdNext;
  assign stat_o.is_rev    = cmd_q == CmdReverse || cmd_q == CmdSwap;
  assign stat_o.rev_more  = (cmd_q == CmdSwap) ? (i_q != j_q) : (i_q < j_q);
  assign stat_o.at_lo     = i_q <= a_q;
  assign stat_o.scan_more = (i_q > a_q) && (eim1 >= ei);
  assign stat_o.j_more    = ej <= epiv;

  always_comb begin
    fill_d = fill_q;
    mask_d = mask_q;
    if (ctrl_i.op == OpSimple && ok) begin
      case (cmd_q)
        CmdSet: begin
          if (a_q == fill_q) begin
            fill_d = fill_q + 1'b1;
          end else begin
            mask_d = mask_d ^ (16'd1 << mem_q[a_q[AW-1:0]]);
          end
          mask_d = mask_d ^ (16'd1 << v_q);
        end
        CmdPush: begin
          fill_d = fill_q + 1'b1;
          mask_d = mask_q ^ (16'd1 << v_q);
        end
        CmdPop: begin
          if (fill_q != '0) begin
            fill_d = fill_q - 1'b1;
            mask_d = mask_q ^ (16'd1 << mem_q[AW'(fill_q - 1'b1)]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      mask_q <= MaskAllOnes;
      cmd_q  <= CmdPop;
      adv_q  <= 1'b0;
      pend_q <= 1'b0;
      rej_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      mask_q <= mask_d;
      if (ctrl_i.op == OpLoad) begin
        cmd_q  <= command_i;
        adv_q  <= 1'b0;
        pend_q <= 1'b1;
      end else if (pend_q) begin
        rej_q  <= ~ok;
        pend_q <= 1'b0;
      end
      if (ctrl_i.op == OpPivot) adv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OpLoad: begin
        a_q <= a_w;
        b_q <= b_w;
        v_q <= value_i;
        if (command_i == CmdSwap) begin
          i_q <= a_w;
          j_q <= b_w;
        end else if (command_i == CmdNext) begin
          i_q <= (b_w == '0) ? a_w : bm1_w;
          j_q <= bm1_w;
        end else begin
          i_q <= a_w;
          j_q <= bm1_w;
        end
      end
      OpSimple: begin
        if (ok && (cmd_q == CmdSet || cmd_q == CmdPush)) begin
          if (cmd_q == CmdSet) mem_q[a_q[AW-1:0]] <= v_q;
          else                 mem_q[fill_q[AW-1:0]] <= v_q;
        end
      end
      OpSwapIJ: begin
        mem_q[i_q[AW-1:0]] <= ej;
        mem_q[j_q[AW-1:0]] <= ei;
        i_q <= i_q + 1'b1;
        if (cmd_q == CmdSwap) j_q <= i_q + 1'b1;
        else                  j_q <= j_q - 1'b1;
      end
      OpScanDn: i_q <= i_q - 1'b1;
      OpPivot: begin
        piv_q <= i_q - 1'b1;
        j_q   <= b_q - 1'b1;
      end
      OpScanJ: j_q <= j_q - 1'b1;
      OpSwapPiv: begin
        mem_q[piv_q[AW-1:0]] <= ej;
        mem_q[j_q[AW-1:0]]   <= epiv;
        j_q <= b_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign status_o       = rej_q;
  assign advanced_o     = adv_q;
  assign filled_count_o = 5'(fill_q);
  assign unused_mask_o  = mask_q;
  assign entry_at_a_o   = (a_q < fill_q) ? mem_q[a_q[AW-1:0]] : 4'd0;

endmodule

@@ src/ppe_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppe_ctrl: sequencer of the permutation engine
// Walks each command through its datapath operations and runs the handshake.
// ----------------------------------------------------------------------------
module ppe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ppe_pkg::stat_t stat_i,
  output ppe_pkg::ctrl_t ctrl_o
);
  import ppe_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SExec  = 3'd1;
  localparam logic [2:0] SRev   = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SFindJ = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = state_q == SDone;

  always_comb begin
    state_d   = state_q;
    ctrl_o.op = OpNone;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctrl_o.op = OpLoad;
          state_d   = SExec;
        end
      end
      SExec: begin
        if (!stat_i.ok) begin
          state_d = SDone;
        end else if (stat_i.is_rev) begin
          state_d = SRev;
        end else if (stat_i.is_next) begin
          state_d = SScan;
        end else begin
          ctrl_o.op = OpSimple;
          state_d   = SDone;
        end
      end
      SRev: begin
        if (stat_i.rev_more) ctrl_o.op = OpSwapIJ;
        else                 state_d   = SDone;
      end
      SScan: begin
        if (stat_i.scan_more) begin
          ctrl_o.op = OpScanDn;
        end else if (stat_i.at_lo) begin
          state_d = SRev;
        end else begin
          ctrl_o.op = OpPivot;
          state_d   = SFindJ;
        end
      end
      SFindJ: begin
        if (stat_i.j_more) begin
          ctrl_o.op = OpScanJ;
        end else begin
          ctrl_o.op = OpSwapPiv;
          state_d   = SRev;
        end
      end
      SDone: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/partial_permutation_engine.sv @@
// ----------------------------------------------------------------------------
// partial_permutation_engine: partial permutation store with range commands
// Set, push, pop, swap, reverse and next lexicographic order over a range.
// ----------------------------------------------------------------------------
// Usage: one command word enters on the in_valid_i/in_ready_o channel, and
// exactly one result word leaves on out_valid_o/out_ready_i.
// The block works on one word at a time; in_ready_o is high only when idle.
// Set, push, pop and rejected commands finish straight from the execute
// state. Reverse and swap exchange entries pairwise in the reversal state.
// Next permutation scans down the descending tail one entry a cycle, searches
// the successor one entry a cycle, swaps, then reverses the tail one pair a
// cycle.
// A result is held until out_ready_i takes it; the next word is accepted the
// cycle after.
// Reset empties the store, sets the unused mask to all ones and
// perm_length to 16. perm_length_wr_i writes the length without wait.
// ----------------------------------------------------------------------------
module partial_permutation_engine #(
  parameter int unsigned MaxLength = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        perm_length_wr_i,
  input  logic [4:0]  perm_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [4:0]  index_a_i,
  input  logic [4:0]  index_b_i,
  input  logic [3:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        advanced_o,
  output logic [4:0]  filled_count_o,
  output logic [15:0] unused_mask_o,
  output logic [3:0]  entry_at_a_o
);
  import ppe_pkg::*;

  logic [4:0] len_q;
  ctrl_t      ctrl;
  stat_t      stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 5'd16;
    end else if (perm_length_wr_i) begin
      len_q <= perm_length_i;
    end
  end

  ppe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  ppe_datapath #(.MaxLength(MaxLength)) u_dp (
    .clk_i, .rst_ni, .perm_length_i(len_q), .command_i, .index_a_i, .index_b_i,
    .value_i, .ctrl_i(ctrl), .stat_o(stat), .status_o, .advanced_o,
    .filled_count_o, .unused_mask_o, .entry_at_a_o
  );

endmodule

@@ src/ppe_checker.sv @@
// ----------------------------------------------------------------------------
// ppe_checker: port-level checks of the permutation engine
// Watches the handshake and result consistency at the top-level ports.
// ----------------------------------------------------------------------------
module ppe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic        advanced_o,
  input logic [4:0]  filled_count_o
);

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("second word taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(filled_count_o))
    else $error("result dropped");

  a_adv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(advanced_o && status_o)) else $error("advanced on reject");

endmodule

bind partial_permutation_engine ppe_checker u_ppe_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .advanced_o, .filled_count_o
);

@@ verif/tb_partial_permutation_engine.sv @@
// ----------------------------------------------------------------------------
// tb_partial_permutation_engine: self-checking test of the permutation engine
// Drives command words through the valid/ready input, predicts every result
// word with a behavioral copy of the engine state and compares each field.
// ----------------------------------------------------------------------------
module tb_partial_permutation_engine;
  import ppe_pkg::*;

  typedef struct packed {
    logic        status;
    logic        advanced;
    logic [4:0]  filled;
    logic [15:0] mask;
    logic [3:0]  entry;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        perm_length_wr_i = 1'b0;
  logic [4:0]  perm_length_i = 5'd16;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [4:0]  index_a_i = '0;
  logic [4:0]  index_b_i = '0;
  logic [3:0]  value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic        advanced_o;
  logic [4:0]  filled_count_o;
  logic [15:0] unused_mask_o;
  logic [3:0]  entry_at_a_o;

  logic [3:0]  perm_entries [16];
  logic [4:0]  perm_fill;
  logic [15:0] perm_unused;
  logic [4:0]  perm_len;
  result_t     expected_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          hold_off = 1'b0;

  partial_permutation_engine DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("tb_partial_permutation_engine NOT OK");
      $finish;
    end
  end

  function automatic void flip_bit(logic [3:0] v);
    perm_unused[v] = ~perm_unused[v];
  endfunction

  function automatic void reverse_span(int lo, int hi);
    logic [3:0] t;
    while (lo + 1 < hi) begin
      hi--;
      t = perm_entries[lo];
      perm_entries[lo] = perm_entries[hi];
      perm_entries[hi] = t;
      lo++;
    end
  endfunction

  function automatic bit advance_span(int lo, int hi);
    int i, j;
    logic [3:0] t;
    if (hi - lo < 2) return 1'b0;
    i = hi - 1;
    while (i > lo && perm_entries[i-1] >= perm_entries[i]) i--;
    if (i == lo) begin
      reverse_span(lo, hi);
      return 1'b0;
    end
    i--;
    j = hi - 1;
    while (perm_entries[j] <= perm_entries[i]) j--;
    t = perm_entries[i];
    perm_entries[i] = perm_entries[j];
    perm_entries[j] = t;
    reverse_span(i + 1, hi);
    return 1'b1;
  endfunction

  function automatic result_t predict_command(logic [2:0] cmd, logic [4:0] a,
                                              logic [4:0] b, logic [3:0] v);
    result_t r;
    logic [3:0] t;
    int len;
    len = (perm_len > 16) ? 16 : perm_len;
    r = '0;
    case (cmd)
      CmdSet: begin
        if (a == perm_fill && perm_fill < len) begin
          perm_entries[a] = v;
          perm_fill++;
          flip_bit(v);
        end else if (a < perm_fill && perm_fill <= len) begin
          flip_bit(perm_entries[a]);
          flip_bit(v);
          perm_entries[a] = v;
        end else r.status = 1'b1;
      end
      CmdPush: begin
        if (perm_fill < len) begin
          perm_entries[perm_fill] = v;
          perm_fill++;
          flip_bit(v);
        end else r.status = 1'b1;
      end
      CmdPop: begin
        if (perm_fill > 0) begin
          flip_bit(perm_entries[perm_fill-1]);
          perm_fill--;
        end
      end
      CmdSwap: begin
        if (a < perm_fill && b < perm_fill) begin
          t = perm_entries[a];
          perm_entries[a] = perm_entries[b];
          perm_entries[b] = t;
        end else r.status = 1'b1;
      end
      CmdReverse: begin
        if (a < perm_fill && b <= perm_fill && a <= b) reverse_span(a, b);
        else r.status = 1'b1;
      end
      CmdNext: begin
        if (perm_fill == len && b <= len && a <= b) r.advanced = advance_span(a, b);
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.filled = perm_fill;
    r.mask = perm_unused;
    r.entry = (a < perm_fill) ? perm_entries[a] : 4'd0;
    return r;
  endfunction

  task automatic send_command(logic [2:0] cmd, logic [4:0] a, logic [4:0] b,
                              logic [3:0] v, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10));
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    index_a_i <= a;
    index_b_i <= b;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_command(cmd, a, b, v));
    items_sent++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_length(logic [4:0] len);
    drain_results();
    perm_length_wr_i <= 1'b1;
    perm_length_i <= len;
    @(posedge clk_i);
    perm_length_wr_i <= 1'b0;
    perm_len = len;
  endtask

  // Receiver: random stall per word, plus a long hold-off when requested.
  initial begin
    int stall;
    result_t got, exp_r;
    forever begin
      @(posedge clk_i);
      if (!hold_off && !out_ready_i) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (out_ready_i && out_valid_o) begin
        got = {status_o, advanced_o, filled_count_o, unused_mask_o, entry_at_a_o};
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
        if ($urandom_range(0, 1) == 0 || hold_off) out_ready_i <= 1'b0;
      end else if (hold_off) out_ready_i <= 1'b0;
    end
  end

  task automatic fill_ascending(int n);
    while (perm_fill > 0) send_command(CmdPop, 0, 0, 0);
    for (int k = 0; k < n; k++) send_command(CmdPush, 0, 0, k[3:0]);
  endtask

  task automatic test_directed();
    send_command(CmdPop, 0, 0, 0);
    send_command(CmdSwap, 0, 0, 0);
    send_command(CmdReverse, 0, 0, 0);
    send_command(CmdNext, 0, 0, 0);
    send_command(CmdSet, 1, 0, 4'hf);
    send_command(CmdSet, 0, 0, 4'hf);
    send_command(CmdSet, 0, 31, 4'h0);
    send_command(3'd6, 31, 31, 4'hf);
    send_command(3'd7, 0, 0, 0);
    fill_ascending(16);
    send_command(CmdPush, 0, 0, 3);
    send_command(CmdNext, 0, 16, 0);
    send_command(CmdNext, 14, 16, 0);
    send_command(CmdNext, 3, 4, 0);
    send_command(CmdReverse, 0, 16, 0);
    send_command(CmdNext, 0, 16, 0);
    send_command(CmdSwap, 15, 0, 0);
    send_command(CmdSwap, 16, 0, 0);
    send_command(CmdReverse, 5, 4, 0);
    send_command(CmdSet, 15, 0, 4'h5);
  endtask

  task automatic test_random_mix(int count);
    int len;
    for (int k = 0; k < count; k++) begin
      len = (perm_len > 16) ? 16 : perm_len;
      if (perm_fill < len && $urandom_range(0, 2) == 0)
        send_command(CmdPush, 0, 0, 4'($urandom_range(0, 15)));
      else if ($urandom_range(0, 9) == 0)
        send_command(3'($urandom), 5'($urandom), 5'($urandom), 4'($urandom));
      else begin
        logic [4:0] a, b;
        a = 5'($urandom_range(0, 16));
        b = 5'($urandom_range(a, 16));
        send_command(3'($urandom_range(0, 5)), a, b, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic test_permutation_walk(int n, int steps);
    fill_ascending(n);
    for (int k = 0; k < steps; k++) begin
      logic [4:0] a;
      a = 5'($urandom_range(0, n));
      send_command(CmdNext, $urandom_range(0, 3) == 0 ? a : 5'd0,
                   $urandom_range(0, 3) == 0 ? 5'(n) : 5'($urandom_range(a, n)), 0);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_off = 1'b1;
    fork
      for (int k = 0; k < 6; k++) send_command(CmdPop, 0, 0, 0, 1'b1);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain_results();
  endtask

  initial begin
    perm_len = 5'd16;
    perm_fill = '0;
    perm_unused = MaskAllOnes;
    foreach (perm_entries[k]) perm_entries[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(400);
    test_permutation_walk(16, 150);
    write_length(5'd1);
    test_random_mix(150);
    write_length(5'd0);
    test_random_mix(60);
    write_length(5'd4);
    test_permutation_walk(4, 100);
    test_random_mix(300);
    test_backpressure();
    write_length(5'd31);
    test_random_mix(200);
    write_length(5'd7);
    test_permutation_walk(7, 150);
    test_random_mix(300);
    write_length(5'd16);
    test_random_mix(200);
    drain_results();
    $display("Sent %0d command words over lengths 0..31; checked %0d results.",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("tb_partial_permutation_engine OK");
    end else begin
      $display("tb_partial_permutation_engine NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ppe_pkg.sv
src/ppe_datapath.sv
src/ppe_ctrl.sv
src/partial_permutation_engine.sv
src/ppe_checker.sv
verif/tb_partial_permutation_engine.sv
